/* hdl/ipnp_pkg.sv */
// Shared types and constants for the IPv4 network prefix parser.
// No dependencies; used by every other file of the block.
package ipnp_pkg;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_DOT   = 8'd46;
    localparam logic [7:0] CHAR_SLASH = 8'd47;

    // prefix length limits
    localparam logic [5:0] PREFIX_MAX = 6'd32;
    localparam logic [5:0] PREFIX_SAT = 6'd33;

    // component accumulator saturates at 2^32
    localparam logic [32:0] ACC_SAT = 33'h1_0000_0000;

    // octets in an address
    localparam logic [2:0] OCTET_COUNT = 3'd4;

    // one character request
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    // one parse result
    typedef struct packed {
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic        prefix_known;
        logic [1:0]  status;
    } result_t;

endpackage

/* hdl/ipnp_in_reg.sv */
// Input register of the IPv4 network prefix parser: holds one character request.
// Depends on ipnp_pkg.
module ipnp_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ipnp_pkg::in_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output ipnp_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    ipnp_pkg::in_item_t item_reg;

    // free when empty or when the held character moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/ipnp_parse_core.sv */
// Parse state and per-character next-state / result logic of the IPv4 prefix parser.
// Depends on ipnp_pkg.
module ipnp_parse_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_write,
    input  logic               cfg_allow_trailing,
    input  logic               advance,
    input  ipnp_pkg::in_item_t item,
    output ipnp_pkg::result_t  result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_NUM,
        PH_ADDR_DONE,
        PH_PREFIX,
        PH_TRAIL_NOPFX,
        PH_TRAIL_PFX,
        PH_ERR
    } phase_t;

    phase_t      phase_reg, phase_next, fin_phase;
    logic [32:0] acc_reg, acc_next;
    logic [31:0] partial_reg, partial_next, fin_partial;
    logic [2:0]  idx_reg, idx_next, idx_inc;
    logic [5:0]  pfx_reg, pfx_next, pfx_sat;
    logic [1:0]  err_reg, err_next, fin_err;
    logic        allow_reg;

    logic        is_digit;
    logic [3:0]  digit;
    logic [36:0] acc_mul;
    logic [32:0] acc_sat;
    logic [8:0]  pfx_mul;
    logic        is_slash;

    logic [1:0]  status;
    logic [5:0]  len;
    logic        has_prefix;
    logic        trailing;
    logic [31:0] mask;

    // component fits the bits left below the octets already filled
    function automatic logic comp_fits(input logic [32:0] acc, input logic [1:0] idx);
        logic ok;
        case (idx)
            2'd0:    ok = !acc[32];
            2'd1:    ok = !(|acc[32:24]);
            2'd2:    ok = !(|acc[32:16]);
            default: ok = !(|acc[32:8]);
        endcase
        return ok;
    endfunction

    // place an octet at its position from the top
    function automatic logic [31:0] octet_place(input logic [7:0] val, input logic [1:0] idx);
        logic [31:0] word;
        case (idx)
            2'd0:    word = {val, 24'd0};
            2'd1:    word = {8'd0, val, 16'd0};
            2'd2:    word = {16'd0, val, 8'd0};
            default: word = {24'd0, val};
        endcase
        return word;
    endfunction

    // character classes and decimal accumulate
    assign is_digit = (item.char_code >= ipnp_pkg::CHAR_ZERO) &&
                      (item.char_code <= ipnp_pkg::CHAR_NINE);
    assign digit    = item.char_code[3:0];
    assign is_slash = (item.char_code == ipnp_pkg::CHAR_SLASH);
    assign acc_mul  = 37'({acc_reg, 3'b000}) + 37'({acc_reg, 1'b0}) + 37'(digit);
    assign acc_sat  = (|acc_mul[36:32]) ? ipnp_pkg::ACC_SAT : acc_mul[32:0];
    assign pfx_mul  = {pfx_reg, 3'b000} + 9'({pfx_reg, 1'b0}) + 9'(digit);
    assign pfx_sat  = (pfx_mul > 9'(ipnp_pkg::PREFIX_MAX)) ? ipnp_pkg::PREFIX_SAT
                                                           : pfx_mul[5:0];
    assign idx_inc  = idx_reg + 3'd1;

    // per-character step, then string close on the last character
    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        partial_next = partial_reg;
        idx_next     = idx_reg;
        pfx_next     = pfx_reg;
        err_next     = err_reg;

        case (phase_reg)
            PH_START: begin
                if (is_digit) begin
                    acc_next   = 33'(digit);
                    phase_next = PH_NUM;
                end else begin
                    err_next   = ipnp_pkg::ST_INVALID;
                    phase_next = PH_ERR;
                end
            end
            PH_NUM: begin
                if (is_digit) begin
                    acc_next = acc_sat;
                end else if (item.char_code == ipnp_pkg::CHAR_DOT) begin
                    if (|acc_reg[32:8]) begin
                        err_next   = ipnp_pkg::ST_RANGE;
                        phase_next = PH_ERR;
                    end else begin
                        partial_next = partial_reg | octet_place(acc_reg[7:0], idx_reg[1:0]);
                        acc_next     = '0;
                        idx_next     = idx_inc;
                        if (idx_inc >= ipnp_pkg::OCTET_COUNT) begin
                            phase_next = PH_ADDR_DONE;
                        end
                    end
                end else if (comp_fits(acc_reg, idx_reg[1:0])) begin
                    partial_next = partial_reg | acc_reg[31:0];
                    phase_next   = is_slash ? PH_PREFIX : PH_TRAIL_NOPFX;
                end else begin
                    err_next   = ipnp_pkg::ST_RANGE;
                    phase_next = PH_ERR;
                end
            end
            PH_ADDR_DONE: begin
                phase_next = is_slash ? PH_PREFIX : PH_TRAIL_NOPFX;
            end
            PH_PREFIX: begin
                if (is_digit) begin
                    pfx_next = pfx_sat;
                end else begin
                    phase_next = PH_TRAIL_PFX;
                end
            end
            PH_TRAIL_NOPFX, PH_TRAIL_PFX: begin
                phase_next = phase_reg;
            end
            default: begin
                if (err_reg == ipnp_pkg::ST_OK) begin
                    err_next = ipnp_pkg::ST_INVALID;
                end
                phase_next = PH_ERR;
            end
        endcase

        // close a component still open at the end of the string
        fin_phase   = phase_next;
        fin_err     = err_next;
        fin_partial = partial_next;
        if (phase_next == PH_NUM) begin
            if (comp_fits(acc_next, idx_next[1:0])) begin
                fin_partial = partial_next | acc_next[31:0];
                fin_phase   = PH_ADDR_DONE;
            end else begin
                fin_err   = ipnp_pkg::ST_RANGE;
                fin_phase = PH_ERR;
            end
        end

        // status and prefix length
        status     = ipnp_pkg::ST_OK;
        len        = '0;
        has_prefix = (fin_phase == PH_PREFIX) || (fin_phase == PH_TRAIL_PFX);
        trailing   = (fin_phase == PH_TRAIL_NOPFX) || (fin_phase == PH_TRAIL_PFX);
        if (fin_phase == PH_ERR || fin_phase == PH_START) begin
            status = (fin_err != ipnp_pkg::ST_OK) ? fin_err : ipnp_pkg::ST_INVALID;
        end else if (trailing && !allow_reg) begin
            status = ipnp_pkg::ST_INVALID;
        end else if (has_prefix) begin
            if (pfx_next > ipnp_pkg::PREFIX_MAX) begin
                status = ipnp_pkg::ST_RANGE;
            end else begin
                len = pfx_next;
            end
        end else if (!fin_partial[31]) begin
            len = 6'd8;
        end else if (!fin_partial[30]) begin
            len = 6'd16;
        end else if (!fin_partial[29]) begin
            len = 6'd24;
        end else begin
            status = ipnp_pkg::ST_INVALID;
        end

        // mask to the prefix; error results are all ones
        mask = ~(32'hFFFF_FFFF >> len);
        if (status == ipnp_pkg::ST_OK) begin
            result.address      = fin_partial & mask;
            result.prefix_len   = len;
            result.prefix_known = 1'b1;
            result.status       = ipnp_pkg::ST_OK;
        end else begin
            result.address      = 32'hFFFF_FFFF;
            result.prefix_len   = '0;
            result.prefix_known = 1'b0;
            result.status       = status;
        end

        // a finished string leaves the parser at start
        if (item.last) begin
            phase_next   = PH_START;
            acc_next     = '0;
            partial_next = '0;
            idx_next     = '0;
            pfx_next     = '0;
            err_next     = ipnp_pkg::ST_OK;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            acc_reg     <= '0;
            partial_reg <= '0;
            idx_reg     <= '0;
            pfx_reg     <= '0;
            err_reg     <= ipnp_pkg::ST_OK;
        end else if (advance) begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            partial_reg <= partial_next;
            idx_reg     <= idx_next;
            pfx_reg     <= pfx_next;
            err_reg     <= err_next;
        end
    end

    // trailing-text control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_reg <= 1'b0;
        end else if (cfg_write) begin
            allow_reg <= cfg_allow_trailing;
        end
    end

endmodule

/* hdl/ipnp_out_reg.sv */
// Result register of the IPv4 network prefix parser.
// Depends on ipnp_pkg.
module ipnp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  ipnp_pkg::result_t result,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output ipnp_pkg::result_t m_result
);

    logic              valid_reg;
    ipnp_pkg::result_t result_reg;

    // slot can take a result when empty or emptied this cycle
    assign free = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load && free) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

/* hdl/ipv4_network_prefix_parser.sv */
// Top level of the IPv4 network prefix parser: input register, parse core, result register.
// Depends on ipnp_pkg, ipnp_in_reg, ipnp_parse_core and ipnp_out_reg.
//
// Usage:
//   A network string "a[.b[.c[.d]]][/n]" arrives one character per request on the
//   s_ channel (s_char_code, s_last), with s_last on its final character. One result
//   (m_address, m_prefix_len, m_prefix_known, m_status) leaves on the m_ channel for
//   each string, none for the other characters.
//   The cfg_ channel writes allow_trailing; it is always ready and should be written
//   only between strings.
// Throughput and path:
//   One character per cycle while no string end waits for the result register. The last
//   character of a string is taken into the input register; when it moves on, the
//   result register loads through the per-character accumulate and compare logic.
// Reset: aresetn (synchronous, active low) empties both registers, clears the parse
//   state and sets allow_trailing to 0.
// Stall:
//   Characters that end no string keep flowing while a result waits. A last character
//   waits in the input register until the result register is free, and s_ready then
//   drops until it moves on.
module ipv4_network_prefix_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_allow_trailing,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_address,
    output logic [5:0]  m_prefix_len,
    output logic        m_prefix_known,
    output logic [1:0]  m_status
);

    ipnp_pkg::in_item_t s_item;
    ipnp_pkg::in_item_t item;
    ipnp_pkg::result_t  result;
    ipnp_pkg::result_t  m_result;
    logic               item_valid;
    logic               out_free;
    logic               advance;
    logic               load;

    // configuration is taken at any time
    assign cfg_ready = 1'b1;

    assign s_item.char_code = s_char_code;
    assign s_item.last      = s_last;

    // a character moves on unless it ends a string and the result slot is full
    assign advance = item_valid && (!item.last || out_free);
    assign load    = advance && item.last;

    // input register
    ipnp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // parse state and result logic
    ipnp_parse_core u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write          (cfg_valid && cfg_ready),
        .cfg_allow_trailing (cfg_allow_trailing),
        .advance            (advance),
        .item               (item),
        .result             (result)
    );

    // result register
    ipnp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_address      = m_result.address;
    assign m_prefix_len   = m_result.prefix_len;
    assign m_prefix_known = m_result.prefix_known;
    assign m_status       = m_result.status;

    // a string end that moves on shows up as a result next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("string end did not produce a result");

    // a good result has a known prefix of at most 32 bits
    a_ok_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ipnp_pkg::ST_OK) |->
        (m_prefix_known && m_prefix_len <= ipnp_pkg::PREFIX_MAX))
        else $error("good result with bad prefix");

    // an error result is all ones with no prefix
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ipnp_pkg::ST_OK) |->
        (m_address == 32'hFFFF_FFFF && m_prefix_len == 6'd0 && !m_prefix_known))
        else $error("error result not in error form");

    // a zero-length prefix masks the whole address
    a_zero_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ipnp_pkg::ST_OK && m_prefix_len == 6'd0) |->
        (m_address == 32'd0))
        else $error("zero prefix left address bits");

    // a held last character blocks new requests
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item.last && !out_free) |-> !s_ready)
        else $error("request taken while string end stalled");

endmodule

/* dv/tb.sv */
// Self-checking bench for ipv4_network_prefix_parser: character requests in, parse results out.
// Depends on ipnp_pkg and the parser RTL. Holds its own parse predictor, stimulus and scoreboard.
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOW_LIMIT   = 10;
    localparam int TOP_SHIFT    = 24;
    localparam int OCTET_BITS   = 8;
    localparam logic [5:0] CLASS_A_LEN = 6'd8;
    localparam logic [5:0] CLASS_B_LEN = 6'd16;
    localparam logic [5:0] CLASS_C_LEN = 6'd24;
    localparam logic [7:0] OCTET_MAX   = 8'd255;
    localparam int N_PHASES = 6;

    // where the parser stands inside the current string
    typedef enum logic [2:0] {
        SCAN_FIRST, SCAN_NUMBER, SCAN_ADDR_DONE, SCAN_PREFIX,
        SCAN_TAIL, SCAN_TAIL_PFX, SCAN_FAILED
    } scan_t;

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        bit         drain;
    } pend_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_allow_trailing = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'd0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_address;
    logic [5:0]  m_prefix_len;
    logic        m_prefix_known;
    logic [1:0]  m_status;

    ipv4_network_prefix_parser u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_allow_trailing (cfg_allow_trailing),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_code        (s_char_code),
        .s_last             (s_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_address          (m_address),
        .m_prefix_len       (m_prefix_len),
        .m_prefix_known     (m_prefix_known),
        .m_status           (m_status)
    );

    // clock
    always #(HALF_PERIOD) aclk = ~aclk;

    // stimulus and scoreboard storage
    pend_char_t         char_q[$];
    ipnp_pkg::result_t  parsed_q[$];
    logic [7:0]         txt_buf[$];
    bit          s_busy = 1'b0;
    int          s_gap_pct = 0;
    int          m_stall_pct = 0;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          n_chars = 0;
    int          n_strings = 0;
    int          n_ok = 0;
    int          n_invalid = 0;
    int          n_range = 0;
    int          n_checked = 0;

    // predictor state
    logic [32:0] num_acc;
    logic [31:0] addr_acc;
    logic [2:0]  octet_idx;
    scan_t       scan;
    logic [5:0]  pfx_acc;
    logic [1:0]  err_code;
    logic        trail_ok = 1'b0;

    function automatic bit is_digit(logic [7:0] c);
        return c >= ipnp_pkg::CHAR_ZERO && c <= ipnp_pkg::CHAR_NINE;
    endfunction

    function automatic void clear_parse();
        num_acc   = '0;
        addr_acc  = '0;
        octet_idx = '0;
        scan      = SCAN_FIRST;
        pfx_acc   = '0;
        err_code  = ipnp_pkg::ST_OK;
    endfunction

    function automatic void set_fail(logic [1:0] code);
        err_code = code;
        scan     = SCAN_FAILED;
    endfunction

    // close the component as the last one; it must fit the remaining low bits
    function automatic bit close_final();
        int sh;
        sh = TOP_SHIFT - OCTET_BITS * int'(octet_idx[1:0]);
        if ((num_acc >> (sh + OCTET_BITS)) != 0) begin
            set_fail(ipnp_pkg::ST_RANGE);
            return 1'b0;
        end
        addr_acc += num_acc[31:0];
        return 1'b1;
    endfunction

    // advance the predictor by one accepted character, queue a result on the last one
    function automatic void parse_char(logic [7:0] ch, logic lst);
        logic [63:0]       wide;
        int                sh;
        logic [1:0]        status;
        logic [5:0]        len;
        logic [31:0]       mask;
        bit                with_pfx;
        bit                tail;
        ipnp_pkg::result_t want;
        status = ipnp_pkg::ST_OK;
        len    = '0;
        case (scan)
            SCAN_FIRST: begin
                if (is_digit(ch)) begin
                    num_acc = 33'(ch - ipnp_pkg::CHAR_ZERO);
                    scan    = SCAN_NUMBER;
                end else begin
                    set_fail(ipnp_pkg::ST_INVALID);
                end
            end
            SCAN_NUMBER: begin
                if (is_digit(ch)) begin
                    wide = 64'(num_acc) * 10 + 64'(ch - ipnp_pkg::CHAR_ZERO);
                    num_acc = (wide > 64'hFFFF_FFFF) ? ipnp_pkg::ACC_SAT : wide[32:0];
                end else if (ch == ipnp_pkg::CHAR_DOT) begin
                    if (num_acc > 33'(OCTET_MAX)) begin
                        set_fail(ipnp_pkg::ST_RANGE);
                    end else begin
                        sh = TOP_SHIFT - OCTET_BITS * int'(octet_idx[1:0]);
                        addr_acc += num_acc[31:0] << sh;
                        num_acc = '0;
                        octet_idx++;
                        if (octet_idx >= ipnp_pkg::OCTET_COUNT) scan = SCAN_ADDR_DONE;
                    end
                end else if (close_final()) begin
                    scan = (ch == ipnp_pkg::CHAR_SLASH) ? SCAN_PREFIX : SCAN_TAIL;
                end
            end
            SCAN_ADDR_DONE: begin
                scan = (ch == ipnp_pkg::CHAR_SLASH) ? SCAN_PREFIX : SCAN_TAIL;
            end
            SCAN_PREFIX: begin
                if (is_digit(ch)) begin
                    wide = 64'(pfx_acc) * 10 + 64'(ch - ipnp_pkg::CHAR_ZERO);
                    pfx_acc = (wide > 64'(ipnp_pkg::PREFIX_MAX)) ? ipnp_pkg::PREFIX_SAT
                                                                  : wide[5:0];
                end else begin
                    scan = SCAN_TAIL_PFX;
                end
            end
            SCAN_TAIL, SCAN_TAIL_PFX: ;
            default: begin
                if (err_code == ipnp_pkg::ST_OK) err_code = ipnp_pkg::ST_INVALID;
                scan = SCAN_FAILED;
            end
        endcase

        if (!lst) return;

        if (scan == SCAN_NUMBER && close_final()) scan = SCAN_ADDR_DONE;

        if (scan == SCAN_FAILED || scan == SCAN_FIRST) begin
            status = (err_code != ipnp_pkg::ST_OK) ? err_code : ipnp_pkg::ST_INVALID;
        end else begin
            with_pfx = (scan == SCAN_PREFIX || scan == SCAN_TAIL_PFX);
            tail     = (scan == SCAN_TAIL || scan == SCAN_TAIL_PFX);
            if (tail && !trail_ok) begin
                status = ipnp_pkg::ST_INVALID;
            end else if (with_pfx) begin
                if (pfx_acc > ipnp_pkg::PREFIX_MAX) status = ipnp_pkg::ST_RANGE;
                else len = pfx_acc;
            end else if (!addr_acc[31]) begin
                len = CLASS_A_LEN;
            end else if (!addr_acc[30]) begin
                len = CLASS_B_LEN;
            end else if (!addr_acc[29]) begin
                len = CLASS_C_LEN;
            end else begin
                status = ipnp_pkg::ST_INVALID;
            end
        end

        if (status == ipnp_pkg::ST_OK) begin
            mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - int'(len)));
            want.address      = addr_acc & mask;
            want.prefix_len   = len;
            want.prefix_known = 1'b1;
            want.status       = ipnp_pkg::ST_OK;
            n_ok++;
        end else begin
            want.address      = 32'hFFFF_FFFF;
            want.prefix_len   = '0;
            want.prefix_known = 1'b0;
            want.status       = status;
            if (status == ipnp_pkg::ST_RANGE) n_range++;
            else n_invalid++;
        end
        parsed_q.push_back(want);
        clear_parse();
    endfunction

    // accepted requests feed the predictor, accepted results are checked
    always @(posedge aclk) begin : check_results
        ipnp_pkg::result_t got;
        ipnp_pkg::result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) trail_ok = cfg_allow_trailing;
            if (s_valid && s_ready) begin
                parse_char(s_char_code, s_last);
                n_chars++;
                s_busy = 1'b0;
            end
            if (m_valid && m_ready) begin
                got.address      = m_address;
                got.prefix_len   = m_prefix_len;
                got.prefix_known = m_prefix_known;
                got.status       = m_status;
                if (parsed_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= SHOW_LIMIT)
                        $display("[%0d] unexpected result addr=%h len=%0d known=%0b st=%0d",
                                 cycle_cnt, got.address, got.prefix_len,
                                 got.prefix_known, got.status);
                end else begin
                    want = parsed_q.pop_front();
                    n_checked++;
                    if (got.address !== want.address || got.prefix_len !== want.prefix_len ||
                        got.prefix_known !== want.prefix_known ||
                        got.status !== want.status) begin
                        fail_cnt++;
                        if (fail_cnt <= SHOW_LIMIT)
                            $display({"[%0d] result %0d: exp addr=%h len=%0d known=%0b st=%0d",
                                      " got addr=%h len=%0d known=%0b st=%0d"},
                                     cycle_cnt, n_checked, want.address, want.prefix_len,
                                     want.prefix_known, want.status, got.address,
                                     got.prefix_len, got.prefix_known, got.status);
                    end
                end
            end
        end
    end

    // request driver: a new character only once the previous one is taken
    always @(negedge aclk) begin : drive_chars
        pend_char_t nxt;
        if (aresetn && !s_busy) begin
            if (char_q.size() != 0 && !(char_q[0].drain && parsed_q.size() != 0) &&
                $urandom_range(99) >= s_gap_pct) begin
                nxt = char_q.pop_front();
                s_valid     <= 1'b1;
                s_char_code <= nxt.ch;
                s_last      <= nxt.lst;
                s_busy      = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= m_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, parsed_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // move the built string into the request queue, last flag on its final character
    task automatic push_text(bit drain);
        pend_char_t pc;
        if (txt_buf.size() == 0) txt_buf.push_back(ipnp_pkg::CHAR_ZERO);
        foreach (txt_buf[i]) begin
            pc.ch    = txt_buf[i];
            pc.lst   = (i == txt_buf.size() - 1);
            pc.drain = drain && (i == 0);
            char_q.push_back(pc);
        end
        txt_buf.delete();
        n_strings++;
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) txt_buf.push_back(s[i]);
        push_text(1'b0);
    endtask

    task automatic add_number(logic [63:0] v, int zeros);
        logic [7:0] digs[$];
        repeat (zeros) txt_buf.push_back(ipnp_pkg::CHAR_ZERO);
        do begin
            digs.push_front(ipnp_pkg::CHAR_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digs[i]) txt_buf.push_back(digs[i]);
    endtask

    function automatic logic [7:0] rand_tail_char(bit digits_ok);
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while ((!digits_ok && is_digit(c)) || c == ipnp_pkg::CHAR_DOT ||
               c == ipnp_pkg::CHAR_SLASH);
        return c;
    endfunction

    function automatic int rand_zeros();
        return ($urandom_range(99) < 5) ? int'($urandom_range(1, 3)) : 0;
    endfunction

    // trailing text: one terminating character and up to two random bytes
    task automatic add_tail(bit digits_ok);
        txt_buf.push_back(rand_tail_char(digits_ok));
        repeat ($urandom_range(2)) txt_buf.push_back(8'($urandom_range(255)));
    endtask

    // "a[.b[.c[.d]]][/n]" with random values, some out of range, some with trailing text
    task automatic gen_well_formed();
        int          n;
        int          i;
        int          bits;
        int          pick;
        logic [63:0] v;
        bit          all_dotted;
        n = $urandom_range(1, 4);
        all_dotted = (n == 4) && ($urandom_range(99) < 10);
        for (i = 0; i < n; i++) begin
            if (i > 0) txt_buf.push_back(ipnp_pkg::CHAR_DOT);
            pick = $urandom_range(99);
            if (i < n - 1 || all_dotted) begin
                if (i > 0 && pick < 5) continue;
                else if (pick < 12) v = $urandom_range(256, 999);
                else v = $urandom_range(255);
            end else begin
                bits = 32 - OCTET_BITS * (n - 1);
                if (pick < 55) v = {32'h0, $urandom()} & ((64'd1 << bits) - 1);
                else if (pick < 75) v = $urandom_range(255);
                else if (pick < 83 && i > 0) continue;
                else if (pick < 93) v = (64'd1 << bits) + $urandom_range(999);
                else v = {$urandom(), $urandom()} % 64'd10_000_000_000_000;
            end
            add_number(v, rand_zeros());
        end
        if (all_dotted) txt_buf.push_back(ipnp_pkg::CHAR_DOT);
        pick = $urandom_range(99);
        if (pick < 50) begin
            txt_buf.push_back(ipnp_pkg::CHAR_SLASH);
            pick = $urandom_range(99);
            if (pick < 80) add_number($urandom_range(32), rand_zeros());
            else if (pick < 90) add_number($urandom_range(33, 99), 0);
            else if (pick < 95) ;
            else add_number({$urandom(), $urandom()} % 64'd1_000_000_000_000, 0);
            if ($urandom_range(99) < 12) add_tail(1'b0);
        end else if (pick < 62) begin
            add_tail(all_dotted);
        end
    endtask

    // one string: mostly well formed, some damaged, some plain noise
    task automatic gen_string(bit drain);
        int         pick;
        int         pos;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 70) begin
            gen_well_formed();
        end else if (pick < 85) begin
            gen_well_formed();
            pos = $urandom_range(txt_buf.size() - 1);
            c = 8'($urandom_range(255));
            case ($urandom_range(2))
                0: txt_buf[pos] = c;
                1: txt_buf.insert(pos, c);
                default: while (txt_buf.size() > pos + 1) void'(txt_buf.pop_back());
            endcase
        end else begin
            repeat ($urandom_range(1, 5)) txt_buf.push_back(8'($urandom_range(255)));
        end
        push_text(drain);
    endtask

    task automatic write_allow(logic v);
        @(negedge aclk);
        cfg_valid          <= 1'b1;
        cfg_allow_trailing <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || s_busy || parsed_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // test sequence
    initial begin : run_test
        int ph_allow[N_PHASES] = '{1, 0, 1, 0, 1, 0};
        int ph_gap[N_PHASES]   = '{35, 0, 35, 35, 0, 35};
        int ph_stall[N_PHASES] = '{35, 0, 35, 0, 35, 35};
        int ph_chars[N_PHASES] = '{300, 300, 300, 250, 250, 250};
        int goal;
        int str_idx;
        clear_parse();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed strings with allow_trailing at its reset value
        s_gap_pct   = 35;
        m_stall_pct = 35;
        push_str("9");
        push_str(".");
        push_str("255.255.255.255/32");
        push_str("10.1/");
        push_str("1/33");
        push_str("256.1");
        push_str("1.2.3.4.5");
        push_str("1.2.3.4./24");
        push_str("4294967296");
        push_str("128.1.65536");
        push_str("224");
        push_str("192.168.1");
        push_str("1/40x");
        push_str("+1");
        txt_buf = '{ipnp_pkg::CHAR_ZERO + 8'd1, 8'h00};
        push_text(1'b0);
        txt_buf = '{ipnp_pkg::CHAR_ZERO + 8'd1, 8'hFF};
        push_text(1'b0);
        wait_drained();

        // random phases over both register settings and idling patterns
        for (int p = 0; p < N_PHASES; p++) begin
            write_allow(ph_allow[p][0]);
            s_gap_pct   = ph_gap[p];
            m_stall_pct = ph_stall[p];
            goal    = char_q.size() + ph_chars[p];
            str_idx = 0;
            while (char_q.size() < goal) begin
                gen_string(str_idx == 5 || $urandom_range(99) < 3);
                str_idx++;
            end
            wait_drained();
        end

        $display("covered %0d strings in %0d characters, allow_trailing 0 and 1",
                 n_strings, n_chars);
        $display("predicted %0d ok, %0d invalid, %0d range; %0d results checked",
                 n_ok, n_invalid, n_range, n_checked);
        if (fail_cnt == 0 && parsed_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_cnt, parsed_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
